[src/complex_fixed_point_alu_unit_assert.svh]
// Assertion macros for the complex fixed-point ALU.
// Used by the top level; depends on nothing else.
`ifndef COMPLEX_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define COMPLEX_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CFPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cfpa assertion failed");
`define CFPA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cfpa assertion failed");
`else
`define CFPA_ASSERT(label, clk, rst, prop)
`define CFPA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[src/cfpa_pkg.sv]
// Shared types and constants for the complex fixed-point ALU.
// No dependencies.
package cfpa_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIELD_W        = 32;
   localparam int KIND_W         = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 3'd0,
      KIND_SUB  = 3'd1,
      KIND_MUL  = 3'd2,
      KIND_DIV  = 3'd3,
      KIND_CONJ = 3'd4,
      KIND_NEG  = 3'd5
   } kind_type;

endpackage

[src/complex_fixed_point_alu_unit.sv]
// Top level of the complex fixed-point ALU: multiply, divide and simple ops.
// Depends on cfpa_pkg and complex_fixed_point_alu_unit_assert.svh.
//
//  channel | dir | tdata                              | tuser
//  req     | in  | a_re, a_im, b_re, b_im (32 b each) | kind (3 b)
//  rsp     | out | r_re, r_im (32 b each)             | overflow, divide_by_zero
//
// An item passes DATA_WIDTH + 5 registers before rsp_tvalid rises; one item per cycle
// while rsp_tready does not hold the pipeline.
// The depth is set by the restoring divider, one quotient bit per stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The whole pipeline advances together; it holds only while a result waits and
// rsp_tready is low. A stall freezes every stage, bubbles included, and req_tready
// follows rsp_tready in the same cycle while a result waits.
`include "complex_fixed_point_alu_unit_assert.svh"

module complex_fixed_point_alu_unit #(
   parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // a_re [31:0], a_im [63:32], b_re [95:64], b_im [127:96]
   input  logic [4*cfpa_pkg::FIELD_W-1:0] req_tdata,
   // kind [2:0]
   input  logic [cfpa_pkg::KIND_W-1:0]    req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // r_re [31:0], r_im [63:32]
   output logic [2*cfpa_pkg::FIELD_W-1:0] rsp_tdata,
   // overflow [0], divide_by_zero [1]
   output logic [1:0]                     rsp_tuser
);
   import cfpa_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;          // product width
   localparam int SW = PW + 1;         // sum of two products
   localparam int CW = 3 * W + F;      // divider remainder width
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [PW-1:0]       LIMP = PW'(1) << (W - 1);
   localparam logic [W:0]          LIMQ = (W + 1)'(1) << (W - 1);

   // whole pipeline moves as one
   logic en;

   // ---------------- stage 1: products and simple ops ----------------
   logic signed [W-1:0] a_re, a_im, b_re, b_im;
   kind_type            kind;
   logic signed [W:0]   e_re_sum, e_im_sum;
   logic signed [W-1:0] e_re, e_im;
   logic                e_ovf;

   logic                s1_valid_ff;
   kind_type            s1_kind_ff;
   logic signed [PW-1:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_nr_ff, s1_ni_ff;
   logic signed [W-1:0] s1_re_ff, s1_im_ff;
   logic                s1_ovf_ff;

   assign a_re = req_tdata[W-1:0];
   assign a_im = req_tdata[FIELD_W +: W];
   assign b_re = req_tdata[2*FIELD_W +: W];
   assign b_im = req_tdata[3*FIELD_W +: W];
   assign kind = kind_type'(req_tuser);

   always_comb begin
      e_re_sum = '0;
      e_im_sum = '0;
      case (kind)
         KIND_ADD: begin
            e_re_sum = (W+1)'(a_re) + (W+1)'(b_re);
            e_im_sum = (W+1)'(a_im) + (W+1)'(b_im);
         end
         KIND_SUB: begin
            e_re_sum = (W+1)'(a_re) - (W+1)'(b_re);
            e_im_sum = (W+1)'(a_im) - (W+1)'(b_im);
         end
         KIND_CONJ: begin
            e_re_sum = (W+1)'(a_re);
            e_im_sum = -(W+1)'(a_im);
         end
         KIND_NEG: begin
            e_re_sum = -(W+1)'(a_re);
            e_im_sum = -(W+1)'(a_im);
         end
         default: begin
            e_re_sum = '0;
            e_im_sum = '0;
         end
      endcase
      // clamp each part to the signed range
      e_ovf = 1'b0;
      e_re  = e_re_sum[W-1:0];
      e_im  = e_im_sum[W-1:0];
      if (e_re_sum[W] != e_re_sum[W-1]) begin
         e_ovf = 1'b1;
         e_re  = e_re_sum[W] ? SMIN : SMAX;
      end
      if (e_im_sum[W] != e_im_sum[W-1]) begin
         e_ovf = 1'b1;
         e_im  = e_im_sum[W] ? SMIN : SMAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff <= kind;
         s1_rr_ff   <= PW'(a_re) * PW'(b_re);
         s1_ii_ff   <= PW'(a_im) * PW'(b_im);
         s1_ri_ff   <= PW'(a_re) * PW'(b_im);
         s1_ir_ff   <= PW'(a_im) * PW'(b_re);
         s1_nr_ff   <= PW'(b_re) * PW'(b_re);
         s1_ni_ff   <= PW'(b_im) * PW'(b_im);
         s1_re_ff   <= e_re;
         s1_im_ff   <= e_im;
         s1_ovf_ff  <= e_ovf;
      end
   end

   // ---------------- stage 2: sums of products, divisor norm ----------------
   logic signed [SW-1:0] s2_sum_re_in, s2_sum_im_in;
   logic                 s2_valid_ff;
   kind_type             s2_kind_ff;
   logic signed [SW-1:0] s2_sum_re_ff, s2_sum_im_ff;
   logic [PW-1:0]        s2_n_ff;
   logic signed [W-1:0]  s2_re_ff, s2_im_ff;
   logic                 s2_ovf_ff;

   always_comb begin
      if (s1_kind_ff == KIND_DIV) begin
         // a times conj b
         s2_sum_re_in = SW'(s1_rr_ff) + SW'(s1_ii_ff);
         s2_sum_im_in = SW'(s1_ir_ff) - SW'(s1_ri_ff);
      end else begin
         s2_sum_re_in = SW'(s1_rr_ff) - SW'(s1_ii_ff);
         s2_sum_im_in = SW'(s1_ri_ff) + SW'(s1_ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_sum_re_ff <= s2_sum_re_in;
         s2_sum_im_ff <= s2_sum_im_in;
         s2_n_ff      <= PW'(s1_nr_ff) + PW'(s1_ni_ff);
         s2_re_ff     <= s1_re_ff;
         s2_im_ff     <= s1_im_ff;
         s2_ovf_ff    <= s1_ovf_ff;
      end
   end

   // ---------------- stage 3: sign and magnitude ----------------
   logic [SW-1:0]       s3_abs_re, s3_abs_im;
   logic                s3_valid_ff;
   kind_type            s3_kind_ff;
   logic                s3_neg_re_ff, s3_neg_im_ff, s3_dz_ff;
   logic [PW-1:0]       s3_mag_re_ff, s3_mag_im_ff, s3_n_ff;
   logic signed [W-1:0] s3_re_ff, s3_im_ff;
   logic                s3_ovf_ff;

   assign s3_abs_re = s2_sum_re_ff[SW-1] ? -s2_sum_re_ff : s2_sum_re_ff;
   assign s3_abs_im = s2_sum_im_ff[SW-1] ? -s2_sum_im_ff : s2_sum_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_kind_ff   <= s2_kind_ff;
         s3_neg_re_ff <= s2_sum_re_ff[SW-1];
         s3_neg_im_ff <= s2_sum_im_ff[SW-1];
         s3_mag_re_ff <= s3_abs_re[PW-1:0];
         s3_mag_im_ff <= s3_abs_im[PW-1:0];
         s3_n_ff      <= s2_n_ff;
         s3_dz_ff     <= (s2_kind_ff == KIND_DIV) && (s2_n_ff == '0);
         s3_re_ff     <= s2_re_ff;
         s3_im_ff     <= s2_im_ff;
         s3_ovf_ff    <= s2_ovf_ff;
      end
   end

   // ---------------- stage 4: finish multiply, set up divide ----------------
   localparam logic [PW-1:0] FMASK = (PW'(1) << F) - PW'(1);

   logic [PW-1:0]       m_re, m_im;
   logic signed [W-1:0] s4_re_in, s4_im_in;
   logic                s4_ovf_in, s4_isdiv_in;
   logic [CW-1:0]       d_re, d_im, d_lim;

   always_comb begin
      m_re = (s3_mag_re_ff >> F)
           + PW'(s3_neg_re_ff && ((s3_mag_re_ff & FMASK) != '0));
      m_im = (s3_mag_im_ff >> F)
           + PW'(s3_neg_im_ff && ((s3_mag_im_ff & FMASK) != '0));
      d_re  = CW'(s3_mag_re_ff) << F;
      d_im  = CW'(s3_mag_im_ff) << F;
      d_lim = CW'(s3_n_ff) << W;
      s4_isdiv_in = (s3_kind_ff == KIND_DIV) && !s3_dz_ff;
      s4_re_in  = s3_re_ff;
      s4_im_in  = s3_im_ff;
      s4_ovf_in = s3_ovf_ff;
      case (s3_kind_ff)
         KIND_MUL: begin
            s4_ovf_in = 1'b0;
            if (s3_neg_re_ff ? (m_re > LIMP) : (m_re > LIMP - PW'(1))) begin
               s4_ovf_in = 1'b1;
               s4_re_in  = s3_neg_re_ff ? SMIN : SMAX;
            end else begin
               s4_re_in = s3_neg_re_ff ? -m_re[W-1:0] : m_re[W-1:0];
            end
            if (s3_neg_im_ff ? (m_im > LIMP) : (m_im > LIMP - PW'(1))) begin
               s4_ovf_in = 1'b1;
               s4_im_in  = s3_neg_im_ff ? SMIN : SMAX;
            end else begin
               s4_im_in = s3_neg_im_ff ? -m_im[W-1:0] : m_im[W-1:0];
            end
         end
         KIND_DIV: begin
            // zero divisor leaves zeros; the divider result replaces them later
            s4_re_in  = '0;
            s4_im_in  = '0;
            s4_ovf_in = 1'b0;
         end
         default: begin
            s4_re_in  = s3_re_ff;
            s4_im_in  = s3_im_ff;
            s4_ovf_in = s3_ovf_ff;
         end
      endcase
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic [W:0]          dv_valid_ff;
   logic [W:0]          dv_isdiv_ff, dv_neg_re_ff, dv_neg_im_ff;
   logic [W:0]          dv_big_re_ff, dv_big_im_ff, dv_ovf_ff, dv_dz_ff;
   logic [PW-1:0]       dv_n_ff [0:W];
   logic [CW-1:0]       dv_rem_re_ff [0:W];
   logic [CW-1:0]       dv_rem_im_ff [0:W];
   logic [W-1:0]        dv_quo_re_ff [0:W];
   logic [W-1:0]        dv_quo_im_ff [0:W];
   logic signed [W-1:0] dv_re_ff [0:W];
   logic signed [W-1:0] dv_im_ff [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_isdiv_ff[0]  <= s4_isdiv_in;
         dv_neg_re_ff[0] <= s3_neg_re_ff;
         dv_neg_im_ff[0] <= s3_neg_im_ff;
         // quotient would not fit in W bits: saturate at the end
         dv_big_re_ff[0] <= d_re >= d_lim;
         dv_big_im_ff[0] <= d_im >= d_lim;
         dv_ovf_ff[0]    <= s4_ovf_in;
         dv_dz_ff[0]     <= s3_dz_ff;
         dv_n_ff[0]      <= s3_n_ff;
         dv_rem_re_ff[0] <= d_re;
         dv_rem_im_ff[0] <= d_im;
         dv_quo_re_ff[0] <= '0;
         dv_quo_im_ff[0] <= '0;
         dv_re_ff[0]     <= s4_re_in;
         dv_im_ff[0]     <= s4_im_in;
      end
   end

   for (genvar j = 0; j < W; j++) begin : g_div
      localparam int SH = W - 1 - j;
      logic [CW-1:0] nsh;
      logic [CW:0]   diff_re, diff_im;

      assign nsh     = CW'(dv_n_ff[j]) << SH;
      assign diff_re = {1'b0, dv_rem_re_ff[j]} - {1'b0, nsh};
      assign diff_im = {1'b0, dv_rem_im_ff[j]} - {1'b0, nsh};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_isdiv_ff[j+1]  <= dv_isdiv_ff[j];
            dv_neg_re_ff[j+1] <= dv_neg_re_ff[j];
            dv_neg_im_ff[j+1] <= dv_neg_im_ff[j];
            dv_big_re_ff[j+1] <= dv_big_re_ff[j];
            dv_big_im_ff[j+1] <= dv_big_im_ff[j];
            dv_ovf_ff[j+1]    <= dv_ovf_ff[j];
            dv_dz_ff[j+1]     <= dv_dz_ff[j];
            dv_n_ff[j+1]      <= dv_n_ff[j];
            dv_rem_re_ff[j+1] <= diff_re[CW] ? dv_rem_re_ff[j] : diff_re[CW-1:0];
            dv_rem_im_ff[j+1] <= diff_im[CW] ? dv_rem_im_ff[j] : diff_im[CW-1:0];
            dv_quo_re_ff[j+1] <= (dv_quo_re_ff[j] << 1) | W'(!diff_re[CW]);
            dv_quo_im_ff[j+1] <= (dv_quo_im_ff[j] << 1) | W'(!diff_im[CW]);
            dv_re_ff[j+1]     <= dv_re_ff[j];
            dv_im_ff[j+1]     <= dv_im_ff[j];
         end
      end
   end

   // ---------------- output register: saturate quotient, select ----------------
   logic [W:0]          q_re, q_im;
   logic                sat_re, sat_im;
   logic signed [W-1:0] r_re_in, r_im_in;
   logic                ovf_in;

   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_re_ff, rsp_im_ff;
   logic                rsp_ovf_ff, rsp_dz_ff;

   always_comb begin
      q_re   = {1'b0, dv_quo_re_ff[W]};
      q_im   = {1'b0, dv_quo_im_ff[W]};
      sat_re = dv_big_re_ff[W] || (dv_neg_re_ff[W] ? (q_re > LIMQ) : (q_re >= LIMQ));
      sat_im = dv_big_im_ff[W] || (dv_neg_im_ff[W] ? (q_im > LIMQ) : (q_im >= LIMQ));
      if (dv_isdiv_ff[W]) begin
         r_re_in = sat_re ? (dv_neg_re_ff[W] ? SMIN : SMAX)
                          : (dv_neg_re_ff[W] ? -q_re[W-1:0] : q_re[W-1:0]);
         r_im_in = sat_im ? (dv_neg_im_ff[W] ? SMIN : SMAX)
                          : (dv_neg_im_ff[W] ? -q_im[W-1:0] : q_im[W-1:0]);
         ovf_in  = sat_re || sat_im;
      end else begin
         r_re_in = dv_re_ff[W];
         r_im_in = dv_im_ff[W];
         ovf_in  = dv_ovf_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_re_ff  <= r_re_in;
         rsp_im_ff  <= r_im_in;
         rsp_ovf_ff <= ovf_in;
         rsp_dz_ff  <= dv_dz_ff[W];
      end
   end

   // advance unless a finished item waits at the output
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {FIELD_W'(rsp_im_ff), FIELD_W'(rsp_re_ff)};
   assign rsp_tuser  = {rsp_dz_ff, rsp_ovf_ff};

   // ---------------- assertions ----------------
   logic [FIELD_W-1:0] smax_ext, smin_ext;
   assign smax_ext = FIELD_W'(SMAX);
   assign smin_ext = FIELD_W'(SMIN);

   // a zero divisor gives a clean zero result
   `CFPA_ASSERT(a_dz_zero, clock, reset,
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == '0 && !rsp_tuser[0]))
   // overflow always leaves at least one part at a rail
   `CFPA_ASSERT(a_ovf_rail, clock, reset,
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[FIELD_W-1:0] == smax_ext || rsp_tdata[FIELD_W-1:0] == smin_ext ||
          rsp_tdata[2*FIELD_W-1:FIELD_W] == smax_ext ||
          rsp_tdata[2*FIELD_W-1:FIELD_W] == smin_ext))
   // a waiting result stays valid and steady until taken
   `CFPA_ASSERT(a_stall_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   // no result comes out of reset
   `CFPA_ASSERT_ALWAYS(a_reset_clear, clock,
      $past(reset) |-> !rsp_tvalid)

endmodule

[tb/tb_complex_fixed_point_alu_unit.sv]
// Self-checking bench for the complex fixed-point ALU: directed table, then random items.
// Depends on cfpa_pkg and the complex_fixed_point_alu_unit top level.
module tb_complex_fixed_point_alu_unit;
   import cfpa_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = DW + 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_TAIL = 150;
   localparam logic [31:0] MAXP = 32'h7fffffff;
   localparam logic [31:0] MINN = 32'h80000000;
   localparam logic [31:0] ONE = 32'h00010000;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        ovf;
      logic        dz;
   } alu_result_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] ar, ai, br, bi;
      bit          typed;
      alu_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   alu_result_type pending_results[$];
   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;
   bit hang = 1'b0;

   complex_fixed_point_alu_unit u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturate a wide signed value into the 32-bit result range.
   function automatic logic [31:0] clamp(input logic signed [129:0] v, inout logic ovf);
      if (v > $signed(130'sh7fffffff)) begin
         ovf = 1'b1;
         return MAXP;
      end
      if (v < -$signed(130'sh80000000)) begin
         ovf = 1'b1;
         return MINN;
      end
      return v[31:0];
   endfunction

   // Floor shift for products; >>> on a signed vector rounds toward minus infinity.
   function automatic logic [31:0] scale_product(input logic signed [129:0] s, inout logic ovf);
      return clamp(s >>> FB, ovf);
   endfunction

   // Quotient of (s << FB) / n, truncated toward zero.
   function automatic logic [31:0] scale_quotient(input logic signed [129:0] s,
                                                  input logic signed [129:0] n,
                                                  inout logic ovf);
      logic signed [129:0] num;
      logic [129:0] mag;
      logic [129:0] q;
      num = s <<< FB;
      mag = num < 0 ? -num : num;
      q = mag / n;
      return clamp(num < 0 ? -$signed(q) : $signed(q), ovf);
   endfunction

   function automatic alu_result_type alu_predict(input logic [2:0] kind,
                                                  input logic [31:0] ar_u, ai_u, br_u, bi_u);
      logic signed [129:0] ar, ai, br, bi, nrm;
      alu_result_type r;
      ar = $signed(ar_u);
      ai = $signed(ai_u);
      br = $signed(br_u);
      bi = $signed(bi_u);
      r = '0;
      case (kind)
         KIND_ADD: begin
            r.re = clamp(ar + br, r.ovf);
            r.im = clamp(ai + bi, r.ovf);
         end
         KIND_SUB: begin
            r.re = clamp(ar - br, r.ovf);
            r.im = clamp(ai - bi, r.ovf);
         end
         KIND_MUL: begin
            r.re = scale_product(ar * br - ai * bi, r.ovf);
            r.im = scale_product(ar * bi + ai * br, r.ovf);
         end
         KIND_DIV: begin
            nrm = br * br + bi * bi;
            if (nrm == 0) begin
               r.dz = 1'b1;
            end else begin
               r.re = scale_quotient(ar * br + ai * bi, nrm, r.ovf);
               r.im = scale_quotient(ai * br - ar * bi, nrm, r.ovf);
            end
         end
         KIND_CONJ: begin
            r.re = ar_u;
            r.im = clamp(-ai, r.ovf);
         end
         KIND_NEG: begin
            r.re = clamp(-ar, r.ovf);
            r.im = clamp(-ai, r.ovf);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Directed rows; expectations are typed in only where obvious.
   stim_row_type directed_rows[20] = '{
      '{KIND_ADD, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{KIND_ADD, MAXP, MINN, ONE, MINN, 1, '{MAXP, MINN, 1, 0}},
      '{KIND_SUB, MINN, MAXP, ONE, MINN, 1, '{MINN, MAXP, 1, 0}},
      '{KIND_SUB, ONE, ONE, ONE, 0, 1, '{0, ONE, 0, 0}},
      '{KIND_MUL, ONE, 0, ONE, 0, 1, '{ONE, 0, 0, 0}},
      '{KIND_MUL, MAXP, MAXP, MAXP, MINN, 0, '{0, 0, 0, 0}},
      '{KIND_MUL, MINN, MINN, MINN, MINN, 0, '{0, 0, 0, 0}},
      '{KIND_MUL, 32'hffffffff, 0, 1, 0, 1, '{32'hffffffff, 0, 0, 0}},
      '{KIND_DIV, ONE, ONE, 0, 0, 1, '{0, 0, 0, 1}},
      '{KIND_DIV, MAXP, MINN, 0, 0, 1, '{0, 0, 0, 1}},
      '{KIND_DIV, ONE, 0, ONE, 0, 1, '{ONE, 0, 0, 0}},
      '{KIND_DIV, MAXP, MAXP, 1, 0, 1, '{MAXP, MAXP, 1, 0}},
      '{KIND_DIV, MINN, MINN, 1, 1, 0, '{0, 0, 0, 0}},
      '{KIND_DIV, 32'hffffffff, 0, 32'h00030000, 0, 0, '{0, 0, 0, 0}},
      '{KIND_CONJ, MINN, MINN, MAXP, MAXP, 1, '{MINN, MAXP, 1, 0}},
      '{KIND_CONJ, MAXP, MAXP, 0, 0, 1, '{MAXP, 32'h80000001, 0, 0}},
      '{KIND_NEG, MINN, 0, 0, 0, 1, '{MAXP, 0, 1, 0}},
      '{KIND_NEG, MAXP, ONE, 0, 0, 1, '{32'h80000001, 32'hffff0000, 0, 0}},
      '{3'd6, MAXP, MAXP, MAXP, MAXP, 1, '{0, 0, 0, 0}},
      '{3'd7, MINN, MINN, MINN, MINN, 1, '{0, 0, 0, 0}}
   };

   // Operand with a bias toward extremes, small values and all-ones patterns.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return MAXP;
         1: return MINN;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
         default: return $urandom;
      endcase
   endfunction

   // Offer one item at the falling edge and hold it until accepted.
   // Valid stays high between items unless an idle burst drops it.
   task automatic send_item(input logic [2:0] kind, input logic [31:0] ar, ai, br, bi,
                            input bit typed, input alu_result_type want);
      alu_result_type model;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tuser <= kind;
      req_tdata <= {bi, br, ai, ar};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = alu_predict(kind, ar, ai, br, bi);
      if (typed && model !== want) begin
         $error("table row disagrees with predictor: kind %0d", kind);
         errors++;
      end
      pending_results.push_back(model);
      n_accepted++;
      @(negedge clock);
   endtask

   // Sample results at the rising edge and compare with the oldest expectation.
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            n_checked++;
            if (rsp_tdata[31:0] !== exp_r.re) begin
               $error("r_re: expected %h, actual %h", exp_r.re, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== exp_r.im) begin
               $error("r_im: expected %h, actual %h", exp_r.im, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser[0] !== exp_r.ovf) begin
               $error("overflow: expected %b, actual %b", exp_r.ovf, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== exp_r.dz) begin
               $error("divide_by_zero: expected %b, actual %b", exp_r.dz, rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   // Stall the result side in random bursts; none during the quiet tail.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(1, 11));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) hang <= 1'b1;
   end

   initial begin
      int k;
      logic [31:0] ar, ai, br, bi;
      logic [2:0] kind;
      fork
         begin
            repeat (8) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
            foreach (directed_rows[i]) begin
               send_item(directed_rows[i].kind, directed_rows[i].ar, directed_rows[i].ai,
                         directed_rows[i].br, directed_rows[i].bi, directed_rows[i].typed,
                         directed_rows[i].want);
            end
            // Drain the pipe once before the random part.
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
            for (k = 0; k < RANDOM_ITEMS; k++) begin
               if (k == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
               kind = $urandom_range(0, 14) == 0 ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
               ar = pick_operand();
               ai = pick_operand();
               br = pick_operand();
               bi = pick_operand();
               // Zero divisors now and then.
               if (kind == KIND_DIV && $urandom_range(0, 9) == 0) begin
                  br = '0;
                  bi = '0;
               end
               send_item(kind, ar, ai, br, bi, 1'b0, '0);
            end
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
            repeat (LATENCY + 5) @(negedge clock);
         end
         wait (hang);
      join_any
      if (hang) begin
         $display("FAIL complex_fixed_point_alu_unit");
         $finish;
      end else begin
         $display("Covered all six operations plus unused codes, saturation and zero divisors:");
         $display("  %0d items sent, %0d results checked", n_accepted, n_checked);
         if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS complex_fixed_point_alu_unit");
         end else begin
            $display("FAIL complex_fixed_point_alu_unit");
         end
         $finish;
      end
   end
endmodule

[files.f]
+incdir+src
src/cfpa_pkg.sv
src/complex_fixed_point_alu_unit.sv
tb/tb_complex_fixed_point_alu_unit.sv
